### design/pcm_pkg.sv
// shared types, constants and tables for the payment and change maker
// no dependencies; imported by every other design file
package pcm_pkg;

  localparam int NUM_DEN     = 11;
  localparam int COUNT_W     = 16;
  localparam int AMOUNT_W    = 20;
  localparam int CHG_W       = 14;
  localparam int LVL_W       = 4;
  localparam int CAP_W       = 15;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 28;
  localparam int PROD_W      = CHG_W + RECIP_W;
  localparam int MUL_W       = COUNT_W + CHG_W;
  localparam int STATUS_W    = 3;
  localparam int DENOM_W     = 4;

  localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

  typedef enum logic [1:0] {
    K_START  = 2'd0,
    K_COIN   = 2'd1,
    K_CANCEL = 2'd2,
    K_LOAD   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OWING     = 3'd0,
    ST_DONE      = 3'd1,
    ST_CHANGE    = 3'd2,
    ST_NO_CHANGE = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_IGNORED   = 3'd5,
    ST_LOADED    = 3'd6
  } out_status_t;

  // coin values in cents, unused codes read as zero
  localparam logic [CHG_W-1:0] DENOM_VALUE [16] = '{
    14'd10000, 14'd5000, 14'd2000, 14'd1000, 14'd500, 14'd200,
    14'd100, 14'd50, 14'd20, 14'd10, 14'd5,
    14'd0, 14'd0, 14'd0, 14'd0, 14'd0
  };

  // ceil(2^28 / value), exact quotient for amounts below 2^14
  localparam logic [RECIP_W-1:0] DENOM_RECIP [16] = '{
    26'd26844, 26'd53688, 26'd134218, 26'd268436, 26'd536871, 26'd1342178,
    26'd2684355, 26'd5368710, 26'd13421773, 26'd26843546, 26'd53687092,
    26'd0, 26'd0, 26'd0, 26'd0, 26'd0
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_EXEC,
    OP_CAP_MUL,
    OP_CAP_ADD,
    OP_DIV,
    OP_MUL,
    OP_FOUND,
    OP_DESCEND,
    OP_UP,
    OP_RETRY,
    OP_EMIT,
    OP_SKIP,
    OP_FAIL
  } dp_op_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_EXEC,
    CS_CAP_MUL,
    CS_CAP_ADD,
    CS_DIV,
    CS_MUL,
    CS_CHK,
    CS_BACK,
    CS_RETRY,
    CS_EMIT,
    CS_FAIL
  } ctrl_state_t;

  typedef struct packed {
    logic out_free;
    logic exec_search;
    logic level_zero;
    logic prune;
    logic rem_zero;
    logic last_level;
    logic trial_zero;
    logic emit_last;
  } dp_status_t;

endpackage

### design/pcm_in_if.sv
// input channel: valid/ready handshake with one request word
// depends on pcm_pkg for field widths
interface pcm_in_if;
  import pcm_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [AMOUNT_W-1:0] amount_cents;
  logic [DENOM_W-1:0]  denom_index;
  logic [COUNT_W-1:0]  load_count;

  modport source (output valid, kind, amount_cents, denom_index, load_count, input ready);
  modport sink   (input valid, kind, amount_cents, denom_index, load_count, output ready);
endinterface

### design/pcm_out_if.sv
// result channel: valid/ready handshake with one result word
// depends on pcm_pkg for field widths
interface pcm_out_if;
  import pcm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [AMOUNT_W-1:0] owed_cents;
  logic [DENOM_W-1:0]  change_denom;
  logic [COUNT_W-1:0]  coin_count;
  logic                last;

  modport source (output valid, status, owed_cents, change_denom, coin_count, last,
                  input ready);
  modport sink   (input valid, status, owed_cents, change_denom, coin_count, last,
                  output ready);
endinterface

### design/payment_and_change_maker.sv
// top level of the payment and change maker
// depends on pcm_pkg, pcm_in_if, pcm_out_if, pcm_ctrl and pcm_dp
//
// in_ch carries one request word: start purchase, insert coin, cancel or
// load an inventory count. out_ch returns one result word per request, or
// one change word per denomination paid out, the final one with last set.
// A request is taken only while the block is idle; ready is low in the
// cycle after each accepted word. A coin that closes a purchase with
// change first sums the stock value of the 11 denominations, a multiply
// and an add step each, then a depth-first search over the denominations:
// a divide step per level visited and, unless it prunes, a multiply and
// a check step, an up and a retry step per backtrack, then one emit step
// per denomination up to and including the last one used. Search time is
// bounded only by the number of count choices tried, which the stock and
// the change amount set. Synchronous reset empties the inventory and paid
// tally and closes any purchase. A stalled receiver holds the result word;
// the block waits before the next word but still takes a request while idle.
module payment_and_change_maker (
  input  logic      clk,
  input  logic      rst_n,
  pcm_in_if.sink    in_ch,
  pcm_out_if.source out_ch
);
  import pcm_pkg::*;

  dp_op_t     op;
  dp_status_t sts;
  logic       ready;

  assign in_ch.ready = ready;

  pcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .op       (op),
    .sts      (sts)
  );

  pcm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .sts       (sts),
    .in_kind   (in_ch.kind),
    .in_amount (in_ch.amount_cents),
    .in_denom  (in_ch.denom_index),
    .in_load   (in_ch.load_count),
    .out_ch    (out_ch)
  );

endmodule

### design/pcm_ctrl.sv
// controller: sequences request handling and the change search
// depends on pcm_pkg; drives the datapath through dp_op_t commands
module pcm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output pcm_pkg::dp_op_t     op,
  input  pcm_pkg::dp_status_t sts
);
  import pcm_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE:    if (in_valid) state_nxt = CS_EXEC;
      CS_EXEC: begin
        if (sts.out_free) state_nxt = sts.exec_search ? CS_CAP_MUL : CS_IDLE;
      end
      CS_CAP_MUL: state_nxt = CS_CAP_ADD;
      CS_CAP_ADD: state_nxt = sts.level_zero ? CS_DIV : CS_CAP_MUL;
      CS_DIV:     state_nxt = sts.prune ? CS_BACK : CS_MUL;
      CS_MUL:     state_nxt = CS_CHK;
      CS_CHK: begin
        if (sts.rem_zero) state_nxt = CS_EMIT;
        else if (sts.last_level) state_nxt = CS_BACK;
        else state_nxt = CS_DIV;
      end
      CS_BACK:    state_nxt = sts.level_zero ? CS_FAIL : CS_RETRY;
      CS_RETRY:   state_nxt = sts.trial_zero ? CS_BACK : CS_DIV;
      CS_EMIT: begin
        if (!sts.trial_zero && sts.out_free && sts.emit_last) state_nxt = CS_IDLE;
      end
      CS_FAIL:    if (sts.out_free) state_nxt = CS_IDLE;
      default:    state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LATCH;
      end
      CS_EXEC:    if (sts.out_free) op = OP_EXEC;
      CS_CAP_MUL: op = OP_CAP_MUL;
      CS_CAP_ADD: op = OP_CAP_ADD;
      CS_DIV:     if (!sts.prune) op = OP_DIV;
      CS_MUL:     op = OP_MUL;
      CS_CHK: begin
        if (sts.rem_zero) op = OP_FOUND;
        else if (!sts.last_level) op = OP_DESCEND;
      end
      CS_BACK:    if (!sts.level_zero) op = OP_UP;
      CS_RETRY:   if (!sts.trial_zero) op = OP_RETRY;
      CS_EMIT: begin
        if (sts.trial_zero) op = OP_SKIP;
        else if (sts.out_free) op = OP_EMIT;
      end
      CS_FAIL:    if (sts.out_free) op = OP_FAIL;
      default:    op = OP_NONE;
    endcase
  end

endmodule

### design/pcm_dp.sv
// datapath: coin inventory, purchase state, search stack and result register
// depends on pcm_pkg and pcm_out_if; commanded by pcm_ctrl
module pcm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcm_pkg::dp_op_t              op,
  output pcm_pkg::dp_status_t          sts,
  input  logic [1:0]                   in_kind,
  input  logic [pcm_pkg::AMOUNT_W-1:0] in_amount,
  input  logic [pcm_pkg::DENOM_W-1:0]  in_denom,
  input  logic [pcm_pkg::COUNT_W-1:0]  in_load,
  pcm_out_if.source                    out_ch
);
  import pcm_pkg::*;

  logic [COUNT_W-1:0]  inv_r   [NUM_DEN];
  logic [COUNT_W-1:0]  paid_r  [NUM_DEN];
  logic [COUNT_W-1:0]  trial_r [NUM_DEN];
  logic [CHG_W-1:0]    rem_r   [NUM_DEN];
  logic [CAP_W-1:0]    cap_r   [NUM_DEN];
  logic [AMOUNT_W-1:0] owed_r;
  logic                active_r;
  logic [LVL_W-1:0]    level_r;
  logic [LVL_W-1:0]    last_k_r;
  logic [CHG_W-1:0]    a_cur_r;
  logic [CAP_W-1:0]    cap_acc_r;
  logic [PROD_W-1:0]   prod_r;
  kind_t               kind_r;
  logic [AMOUNT_W-1:0] amt_r;
  logic [DENOM_W-1:0]  denom_r;
  logic [COUNT_W-1:0]  lc_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [AMOUNT_W-1:0] out_owed_r;
  logic [DENOM_W-1:0]  out_denom_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_last_r;

  logic [LVL_W-1:0]    inv_idx;
  logic [COUNT_W-1:0]  inv_rd, paid_rd, trial_rd;
  logic [CHG_W-1:0]    rem_rd, dv_lvl, dv_in, change, rem_now, rem_back;
  logic [CAP_W-1:0]    cap_rd, cap_sat;
  logic [PROD_W:0]     cap_sum;
  logic                d_ok, coin_ok, val_lt, exec_search, emit_now;
  logic [COUNT_W-1:0]  q_now, i_sel;
  logic [MUL_W-1:0]    mul_in;
  out_status_t         ex_status;
  logic [AMOUNT_W-1:0] ex_owed;

  assign inv_idx  = (op == OP_EXEC) ? denom_r : level_r;
  assign inv_rd   = inv_r[inv_idx];
  assign paid_rd  = paid_r[denom_r];
  assign trial_rd = trial_r[level_r];
  assign rem_rd   = rem_r[level_r];
  assign cap_rd   = cap_r[level_r];
  assign dv_lvl   = DENOM_VALUE[level_r];
  assign dv_in    = DENOM_VALUE[denom_r];

  assign d_ok        = denom_r < DENOM_W'(NUM_DEN);
  assign coin_ok     = active_r && d_ok;
  assign val_lt      = AMOUNT_W'(dv_in) < owed_r;
  assign change      = dv_in - owed_r[CHG_W-1:0];
  assign exec_search = (kind_r == K_COIN) && coin_ok && !val_lt && (change != '0);

  assign mul_in  = MUL_W'(inv_rd) * MUL_W'(dv_lvl);
  assign cap_sum = (PROD_W + 1)'(prod_r) + (PROD_W + 1)'(cap_acc_r);
  assign cap_sat = (cap_sum > (PROD_W + 1)'(CAP_MAX)) ? CAP_MAX : cap_sum[CAP_W-1:0];

  assign q_now    = COUNT_W'(prod_r[PROD_W-1:RECIP_SHIFT]);
  assign i_sel    = (q_now < inv_rd) ? q_now : inv_rd;
  assign rem_now  = a_cur_r - prod_r[CHG_W-1:0];
  assign rem_back = rem_rd + dv_lvl;

  always_comb begin
    ex_status = ST_IGNORED;
    ex_owed   = owed_r;
    case (kind_r)
      K_START: begin
        if (!active_r) begin
          ex_status = (amt_r == '0) ? ST_DONE : ST_OWING;
          ex_owed   = amt_r;
        end
      end
      K_CANCEL: begin
        ex_owed = '0;
        if (active_r) ex_status = ST_CANCELLED;
      end
      K_LOAD: begin
        if (d_ok) ex_status = ST_LOADED;
      end
      K_COIN: begin
        if (coin_ok) begin
          if (val_lt) begin
            ex_status = ST_OWING;
            ex_owed   = owed_r - AMOUNT_W'(dv_in);
          end else begin
            ex_status = ST_DONE;
            ex_owed   = '0;
          end
        end
      end
      default: ex_status = ST_IGNORED;
    endcase
  end

  assign emit_now = ((op == OP_EXEC) && !exec_search) || (op == OP_EMIT) || (op == OP_FAIL);

  // purchase state, inventory and search level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_DEN; k++) begin
        inv_r[k]  <= '0;
        paid_r[k] <= '0;
      end
      owed_r      <= '0;
      active_r    <= 1'b0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_now) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (op)
        OP_EXEC: begin
          case (kind_r)
            K_START: begin
              if (!active_r) begin
                for (int k = 0; k < NUM_DEN; k++) paid_r[k] <= '0;
                if (amt_r != '0) begin
                  owed_r   <= amt_r;
                  active_r <= 1'b1;
                end
              end
            end
            K_CANCEL: begin
              if (active_r) begin
                for (int k = 0; k < NUM_DEN; k++) begin
                  inv_r[k]  <= (inv_r[k] > paid_r[k]) ? inv_r[k] - paid_r[k] : '0;
                  paid_r[k] <= '0;
                end
                active_r <= 1'b0;
                owed_r   <= '0;
              end
            end
            K_LOAD: begin
              if (d_ok) inv_r[denom_r] <= lc_r;
            end
            K_COIN: begin
              if (coin_ok) begin
                if (inv_rd != {COUNT_W{1'b1}}) inv_r[denom_r] <= inv_rd + 1'b1;
                if (paid_rd != {COUNT_W{1'b1}} && (val_lt || change != '0))
                  paid_r[denom_r] <= paid_rd + 1'b1;
                if (val_lt) begin
                  owed_r <= owed_r - AMOUNT_W'(dv_in);
                end else begin
                  owed_r   <= '0;
                  active_r <= 1'b0;
                  if (change == '0) begin
                    for (int k = 0; k < NUM_DEN; k++) paid_r[k] <= '0;
                  end else begin
                    level_r <= LVL_W'(NUM_DEN - 1);
                  end
                end
              end
            end
            default: owed_r <= owed_r;
          endcase
        end
        OP_CAP_ADD: if (level_r != '0) level_r <= level_r - 1'b1;
        OP_DESCEND: level_r <= level_r + 1'b1;
        OP_FOUND:   level_r <= '0;
        OP_UP:      level_r <= level_r - 1'b1;
        OP_RETRY:   level_r <= level_r + 1'b1;
        OP_SKIP:    level_r <= level_r + 1'b1;
        OP_EMIT: begin
          inv_r[level_r] <= inv_rd - trial_rd;
          if (level_r == last_k_r) begin
            level_r <= '0;
            for (int k = 0; k < NUM_DEN; k++) paid_r[k] <= '0;
          end else begin
            level_r <= level_r + 1'b1;
          end
        end
        OP_FAIL: begin
          for (int k = 0; k < NUM_DEN; k++) begin
            inv_r[k]  <= (inv_r[k] > paid_r[k]) ? inv_r[k] - paid_r[k] : '0;
            paid_r[k] <= '0;
          end
        end
        default: level_r <= level_r;
      endcase
    end
  end

  // request word, search stack and result word
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        kind_r  <= kind_t'(in_kind);
        amt_r   <= in_amount;
        denom_r <= in_denom;
        lc_r    <= in_load;
      end
      OP_EXEC: begin
        a_cur_r   <= change;
        cap_acc_r <= '0;
      end
      OP_CAP_MUL: prod_r <= PROD_W'(mul_in);
      OP_CAP_ADD: begin
        cap_r[level_r] <= cap_sat;
        cap_acc_r      <= cap_sat;
      end
      OP_DIV: prod_r <= PROD_W'(a_cur_r) * PROD_W'(DENOM_RECIP[level_r]);
      OP_MUL: begin
        trial_r[level_r] <= i_sel;
        prod_r           <= PROD_W'(MUL_W'(i_sel) * MUL_W'(dv_lvl));
      end
      OP_DESCEND: begin
        rem_r[level_r] <= rem_now;
        a_cur_r        <= rem_now;
      end
      OP_FOUND: last_k_r <= level_r;
      OP_RETRY: begin
        trial_r[level_r] <= trial_rd - 1'b1;
        rem_r[level_r]   <= rem_back;
        a_cur_r          <= rem_back;
      end
      default: a_cur_r <= a_cur_r;
    endcase
    if (op == OP_EXEC) begin
      out_status_r <= ex_status;
      out_owed_r   <= ex_owed;
      out_denom_r  <= '0;
      out_count_r  <= '0;
      out_last_r   <= 1'b1;
    end else if (op == OP_EMIT) begin
      out_status_r <= ST_CHANGE;
      out_owed_r   <= '0;
      out_denom_r  <= DENOM_W'(level_r);
      out_count_r  <= trial_rd;
      out_last_r   <= (level_r == last_k_r);
    end else if (op == OP_FAIL) begin
      out_status_r <= ST_NO_CHANGE;
      out_owed_r   <= '0;
      out_denom_r  <= '0;
      out_count_r  <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign sts.out_free    = !out_valid_r || out_ch.ready;
  assign sts.exec_search = exec_search;
  assign sts.level_zero  = (level_r == '0);
  assign sts.prune       = CAP_W'(a_cur_r) > cap_rd;
  assign sts.rem_zero    = (rem_now == '0);
  assign sts.last_level  = (level_r == LVL_W'(NUM_DEN - 1));
  assign sts.trial_zero  = (trial_rd == '0);
  assign sts.emit_last   = (level_r == last_k_r);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.owed_cents   = out_owed_r;
  assign out_ch.change_denom = out_denom_r;
  assign out_ch.coin_count   = out_count_r;
  assign out_ch.last         = out_last_r;

endmodule

### design/pcm_chk.sv
// port checker for the payment and change maker, bound to the top level
// depends on pcm_pkg for status codes and widths
module pcm_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pcm_pkg::STATUS_W-1:0] out_status,
  input logic [pcm_pkg::AMOUNT_W-1:0] out_owed,
  input logic [pcm_pkg::DENOM_W-1:0]  out_denom,
  input logic [pcm_pkg::COUNT_W-1:0]  out_count,
  input logic                         out_last
);
  import pcm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_owed)
      && $stable(out_denom) && $stable(out_count) && $stable(out_last))
    else $error("result word changed while stalled");

  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_CHANGE) |-> out_last && (out_denom == '0)
      && (out_count == '0))
    else $error("non-change result with coin fields or without last");

  a_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_CHANGE) |-> (out_owed == '0) && (out_count != '0)
      && (out_denom < DENOM_W'(NUM_DEN)))
    else $error("malformed change word");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in progress");

endmodule

bind payment_and_change_maker pcm_chk u_pcm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_owed   (out_ch.owed_cents),
  .out_denom  (out_ch.change_denom),
  .out_count  (out_ch.coin_count),
  .out_last   (out_ch.last)
);
